// ----- rtl/apsp_pkg.sv -----
// shared types, constants and microprogram for the all-pairs shortest path block
// no dependencies; used by the interfaces, the sequencer and the top level
package apsp_pkg;

	localparam int MAX_VERTICES_DEF = 16;
	localparam int DIST_BITS_DEF = 32;

	localparam int VCOUNT_W = 5;
	localparam int MODE_W = 2;
	localparam int VERTEX_W = 4;
	localparam int WEIGHT_W = 16;
	localparam int DISTANCE_W = 32;
	localparam int STEP_W = 5;

	localparam logic [VCOUNT_W-1:0] VERTEX_COUNT_RST = 5'd16;

	typedef enum logic [MODE_W-1:0] {
		MODE_CLEAR = 2'd0,
		MODE_WRITE = 2'd1,
		MODE_CLOSE = 2'd2,
		MODE_READ = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t mode;
		logic [VERTEX_W-1:0] from_vertex;
		logic [VERTEX_W-1:0] to_vertex;
		logic signed [WEIGHT_W-1:0] edge_weight;
	} in_item_t;

	typedef struct packed {
		logic signed [DISTANCE_W-1:0] distance;
		logic unreachable;
		logic status;
	} out_item_t;

	// microprogram addresses; dispatch jumps land on S_JMP_CLR + mode
	typedef enum logic [STEP_W-1:0] {
		S_CLR = 5'd0,
		S_CLR_END = 5'd1,
		S_EMIT = 5'd2,
		S_IDLE = 5'd3,
		S_JMP_CLR = 5'd4,
		S_JMP_WR = 5'd5,
		S_JMP_CL = 5'd6,
		S_JMP_RD = 5'd7,
		S_WR_CHK = 5'd8,
		S_WR_EDGE = 5'd9,
		S_RD_CHK = 5'd10,
		S_RD_ISSUE = 5'd11,
		S_RD_TAKE = 5'd12,
		S_CL_START = 5'd13,
		S_RLX_A = 5'd14,
		S_RLX_B = 5'd15,
		S_RLX_C = 5'd16,
		S_CL_END = 5'd17
	} step_t;

	typedef enum logic [2:0] {
		M_NONE,
		M_CLEAR,
		M_EDGE,
		M_RD_ENTRY,
		M_RD_IKKJ,
		M_RD_IJ,
		M_RELAX
	} mem_op_t;

	typedef enum logic [1:0] {
		K_NONE,
		K_SWEEP_INC,
		K_KIJ_CLR,
		K_KIJ_STEP
	} cnt_op_t;

	typedef enum logic [1:0] {
		R_NONE,
		R_BAD,
		R_ENTRY
	} res_op_t;

	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_SWEEP_MORE,
		C_NO_PEND,
		C_OUT_BUSY,
		C_DISPATCH,
		C_BAD,
		C_NZERO,
		C_KIJ_MORE
	} cond_t;

	typedef struct packed {
		logic ready;
		logic emit;
		mem_op_t mem_op;
		cnt_op_t cnt_op;
		res_op_t res_op;
		cond_t cond;
		step_t target;
	} ctrl_word_t;

	typedef struct packed {
		logic accepted;
		mode_t mode;
		logic sweep_more;
		logic pend;
		logic out_busy;
		logic bad;
		logic n_zero;
		logic kij_more;
	} seq_flags_t;

	// control store: taken branch goes to target, otherwise to the next step; dispatch goes to target plus mode, or holds
	function automatic ctrl_word_t ucode(step_t s);
		ctrl_word_t w;
		w = '{ready: 1'b0, emit: 1'b0, mem_op: M_NONE, cnt_op: K_NONE,
			res_op: R_NONE, cond: C_NEVER, target: S_IDLE};
		case (s)
			S_CLR: begin
				w.mem_op = M_CLEAR;
				w.cnt_op = K_SWEEP_INC;
				w.cond = C_SWEEP_MORE;
				w.target = S_CLR;
			end
			S_CLR_END: begin
				w.cond = C_NO_PEND;
				w.target = S_IDLE;
			end
			S_EMIT: begin
				w.emit = 1'b1;
				w.cond = C_OUT_BUSY;
				w.target = S_EMIT;
			end
			S_IDLE: begin
				w.ready = 1'b1;
				w.cond = C_DISPATCH;
				w.target = S_JMP_CLR;
			end
			S_JMP_CLR: begin
				w.cond = C_ALWAYS;
				w.target = S_CLR;
			end
			S_JMP_WR: begin
				w.cond = C_ALWAYS;
				w.target = S_WR_CHK;
			end
			S_JMP_CL: begin
				w.cond = C_ALWAYS;
				w.target = S_CL_START;
			end
			S_JMP_RD: begin
				w.cond = C_ALWAYS;
				w.target = S_RD_CHK;
			end
			S_WR_CHK: begin
				w.res_op = R_BAD;
				w.cond = C_BAD;
				w.target = S_EMIT;
			end
			S_WR_EDGE: begin
				w.mem_op = M_EDGE;
				w.cond = C_ALWAYS;
				w.target = S_EMIT;
			end
			S_RD_CHK: begin
				w.res_op = R_BAD;
				w.cond = C_BAD;
				w.target = S_EMIT;
			end
			S_RD_ISSUE: begin
				w.mem_op = M_RD_ENTRY;
			end
			S_RD_TAKE: begin
				w.res_op = R_ENTRY;
				w.cond = C_ALWAYS;
				w.target = S_EMIT;
			end
			S_CL_START: begin
				w.cnt_op = K_KIJ_CLR;
				w.cond = C_NZERO;
				w.target = S_EMIT;
			end
			S_RLX_A: begin
				w.mem_op = M_RD_IKKJ;
			end
			S_RLX_B: begin
				w.mem_op = M_RD_IJ;
			end
			S_RLX_C: begin
				w.mem_op = M_RELAX;
				w.cnt_op = K_KIJ_STEP;
				w.cond = C_KIJ_MORE;
				w.target = S_RLX_A;
			end
			S_CL_END: begin
				w.cond = C_ALWAYS;
				w.target = S_EMIT;
			end
			default: begin
				w.cond = C_ALWAYS;
				w.target = S_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

// ----- rtl/apsp_in_if.sv -----
// valid/ready channel carrying one command beat into the block
// depends on apsp_pkg for the beat type
interface apsp_in_if;
	import apsp_pkg::*;

	logic valid;
	logic ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/apsp_out_if.sv -----
// valid/ready channel carrying one result beat out of the block
// depends on apsp_pkg for the beat type
interface apsp_out_if;
	import apsp_pkg::*;

	logic valid;
	logic ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/all_pairs_shortest_path_top.sv -----
// all-pairs shortest path engine: distance matrix in ram, microcoded control
// depends on apsp_pkg, apsp_in_if, apsp_out_if, apsp_ram and apsp_seq

// The block holds a directed distance matrix over up to MAX_VERTICES vertices
// in a single two-read, one-write ram, each entry a signed DIST_BITS value plus
// a no-path flag. Every command beat gives exactly one result beat. Mode 0
// clears the matrix (diagonal zero, all else unreachable), mode 1 writes one
// edge weight, mode 2 runs the Floyd-Warshall closure in place over the first
// vertex_count vertices, mode 3 reads one entry. Sums saturate to the DIST_BITS
// range; a path through an unreachable entry stays unreachable. After reset a
// clearing pass walks every ram entry, one entry per cycle, and no command is
// taken meanwhile; writes to vertex_count are taken at any time. Mode 0 runs
// the same sweep. An out-of-range index in mode 1 or 3 gives a status result
// and leaves the ram alone. In mode 2 each relaxation reads d[i][k] and d[k][j]
// on the two ram ports, then d[i][j], then writes d[i][j] back; as the ram's
// read is registered, these fall in the steps S_RLX_A, S_RLX_B and S_RLX_C.
// Commands are handled one at a time; the result sits in an output register so
// the next command is taken while a result still waits.
module all_pairs_shortest_path_top #(
	parameter int MAX_VERTICES = apsp_pkg::MAX_VERTICES_DEF,
	parameter int DIST_BITS = apsp_pkg::DIST_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [apsp_pkg::VCOUNT_W-1:0] cfg_wdata,
	apsp_in_if.sink item,
	apsp_out_if.source result
);
	import apsp_pkg::*;

	// ram address is {row, column}
	localparam int VIDX_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int CNT_W = $clog2(MAX_VERTICES + 1);
	localparam int AW = 2 * VIDX_W;
	localparam int DEPTH = 1 << AW;
	localparam int EW = DIST_BITS + 1;
	localparam logic signed [63:0] DMAX64 = (64'sd1 <<< (DIST_BITS - 1)) - 64'sd1;
	localparam logic signed [63:0] DMIN64 = -DMAX64 - 64'sd1;
	localparam logic [DIST_BITS-1:0] DMAX_D = DIST_BITS'(DMAX64);
	localparam logic [DIST_BITS-1:0] DMIN_D = DIST_BITS'(DMIN64);
	localparam logic signed [63:0] OMAX64 = (64'sd1 <<< (DISTANCE_W - 1)) - 64'sd1;
	localparam logic signed [63:0] OMIN64 = -OMAX64 - 64'sd1;

	// control and configuration
	ctrl_word_t ctrl;
	seq_flags_t flags;
	logic [VCOUNT_W-1:0] vertex_count_q;
	logic [CNT_W-1:0] n_eff;
	logic [CNT_W-1:0] n_m1;
	logic accepted;
	logic bad;
	logic out_busy;
	logic emit_load;

	// command and result holding registers
	in_item_t in_q;
	out_item_t res_q;
	out_item_t out_q;
	logic out_valid_q;
	logic pend_q;

	// sweep and loop counters
	logic [AW-1:0] sweep_q;
	logic [VIDX_W-1:0] k_q;
	logic [VIDX_W-1:0] i_q;
	logic [VIDX_W-1:0] j_q;
	logic j_last;
	logic i_last;
	logic k_last;
	logic [VIDX_W-1:0] from_idx;
	logic [VIDX_W-1:0] to_idx;

	// ram ports
	logic mem_we;
	logic [AW-1:0] mem_waddr;
	logic [EW-1:0] mem_wdata;
	logic [AW-1:0] mem_raddr_a;
	logic [AW-1:0] mem_raddr_b;
	logic [EW-1:0] rd_a;
	logic [EW-1:0] rd_b;

	// datapath values
	logic [EW-1:0] clr_data;
	logic [EW-1:0] ik_q;
	logic [EW-1:0] kj_q;
	logic signed [63:0] w64;
	logic [DIST_BITS-1:0] edge_val;
	logic signed [DIST_BITS:0] relax_wide;
	logic [DIST_BITS-1:0] relax_sum;
	logic better;
	logic signed [63:0] rd64;
	logic [DISTANCE_W-1:0] rd_dist;

	// handshakes
	assign item.ready = ctrl.ready;
	assign accepted = item.valid && ctrl.ready;
	assign result.valid = out_valid_q;
	assign result.data = out_q;
	assign out_busy = out_valid_q && !result.ready;
	assign emit_load = ctrl.emit && !out_busy;

	// effective vertex count, capped at the matrix size
	always_comb begin
		if (32'(vertex_count_q) > MAX_VERTICES) begin
			n_eff = CNT_W'(MAX_VERTICES);
		end else begin
			n_eff = CNT_W'(vertex_count_q);
		end
		n_m1 = n_eff - CNT_W'(1);
	end

	// index check for edge writes and entry reads
	assign bad = (32'(in_q.from_vertex) >= 32'(n_eff)) ||
		(32'(in_q.to_vertex) >= 32'(n_eff));
	assign from_idx = VIDX_W'(in_q.from_vertex);
	assign to_idx = VIDX_W'(in_q.to_vertex);

	assign j_last = (CNT_W'(j_q) == n_m1);
	assign i_last = (CNT_W'(i_q) == n_m1);
	assign k_last = (CNT_W'(k_q) == n_m1);

	always_comb begin
		flags.accepted = accepted;
		flags.mode = item.data.mode;
		flags.sweep_more = (sweep_q != {AW{1'b1}});
		flags.pend = pend_q;
		flags.out_busy = out_busy;
		flags.bad = bad;
		flags.n_zero = (n_eff == '0);
		flags.kij_more = !(j_last && i_last && k_last);
	end

	apsp_seq u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.flags(flags),
		.ctrl(ctrl)
	);

	// reset pattern for the entry under the sweep: only the diagonal is reachable
	assign clr_data = {(sweep_q[AW-1:VIDX_W] != sweep_q[VIDX_W-1:0]), {DIST_BITS{1'b0}}};

	// edge weight saturated into the distance range
	always_comb begin
		w64 = 64'(in_q.edge_weight);
		if (w64 > DMAX64) begin
			edge_val = DMAX_D;
		end else if (w64 < DMIN64) begin
			edge_val = DMIN_D;
		end else begin
			edge_val = DIST_BITS'(w64);
		end
	end

	// relaxation: saturating d[i][k] + d[k][j], compared against d[i][j]
	always_comb begin
		relax_wide = $signed({ik_q[DIST_BITS-1], ik_q[DIST_BITS-1:0]}) +
			$signed({kj_q[DIST_BITS-1], kj_q[DIST_BITS-1:0]});
		if (relax_wide[DIST_BITS] != relax_wide[DIST_BITS-1]) begin
			relax_sum = relax_wide[DIST_BITS] ? DMIN_D : DMAX_D;
		end else begin
			relax_sum = relax_wide[DIST_BITS-1:0];
		end
		better = !ik_q[DIST_BITS] && !kj_q[DIST_BITS] &&
			(rd_a[DIST_BITS] ||
			($signed(relax_sum) < $signed(rd_a[DIST_BITS-1:0])));
	end

	// read entry saturated to the result width
	always_comb begin
		rd64 = 64'($signed(rd_a[DIST_BITS-1:0]));
		if (rd64 > OMAX64) begin
			rd_dist = DISTANCE_W'(OMAX64);
		end else if (rd64 < OMIN64) begin
			rd_dist = DISTANCE_W'(OMIN64);
		end else begin
			rd_dist = DISTANCE_W'(rd64);
		end
	end

	// ram port steering per micro-op
	always_comb begin
		mem_we = 1'b0;
		mem_waddr = sweep_q;
		mem_wdata = clr_data;
		mem_raddr_a = {i_q, k_q};
		mem_raddr_b = {k_q, j_q};
		case (ctrl.mem_op)
			M_CLEAR: begin
				mem_we = 1'b1;
			end
			M_EDGE: begin
				mem_we = 1'b1;
				mem_waddr = {from_idx, to_idx};
				mem_wdata = {1'b0, edge_val};
			end
			M_RD_ENTRY: begin
				mem_raddr_a = {from_idx, to_idx};
			end
			M_RD_IJ: begin
				mem_raddr_a = {i_q, j_q};
			end
			M_RELAX: begin
				mem_we = better;
				mem_waddr = {i_q, j_q};
				mem_wdata = {1'b0, relax_sum};
			end
			default: begin
			end
		endcase
	end

	apsp_ram #(
		.WIDTH(EW),
		.DEPTH(DEPTH)
	) u_matrix (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr_a(mem_raddr_a),
		.raddr_b(mem_raddr_b),
		.rdata_a_q(rd_a),
		.rdata_b_q(rd_b)
	);

	// control state: config register, beat flags, counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= VERTEX_COUNT_RST;
			out_valid_q <= 1'b0;
			pend_q <= 1'b0;
			sweep_q <= '0;
			k_q <= '0;
			i_q <= '0;
			j_q <= '0;
		end else begin
			if (cfg_we) begin
				vertex_count_q <= cfg_wdata;
			end
			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (accepted) begin
				pend_q <= 1'b1;
			end else if (emit_load) begin
				pend_q <= 1'b0;
			end
			case (ctrl.cnt_op)
				K_SWEEP_INC: begin
					sweep_q <= sweep_q + AW'(1);
				end
				K_KIJ_CLR: begin
					k_q <= '0;
					i_q <= '0;
					j_q <= '0;
				end
				K_KIJ_STEP: begin
					// j innermost, then i, then intermediate k
					if (j_last) begin
						j_q <= '0;
						if (i_last) begin
							i_q <= '0;
							k_q <= k_q + VIDX_W'(1);
						end else begin
							i_q <= i_q + VIDX_W'(1);
						end
					end else begin
						j_q <= j_q + VIDX_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accepted) begin
			in_q <= item.data;
			res_q <= '0;
		end else begin
			case (ctrl.res_op)
				R_BAD: begin
					res_q.status <= bad;
				end
				R_ENTRY: begin
					if (rd_a[DIST_BITS]) begin
						res_q.unreachable <= 1'b1;
					end else begin
						res_q.distance <= rd_dist;
					end
				end
				default: begin
				end
			endcase
		end
		if (ctrl.mem_op == M_RD_IJ) begin
			ik_q <= rd_a;
			kj_q <= rd_b;
		end
		if (emit_load) begin
			out_q <= res_q;
		end
	end
endmodule

// ----- rtl/apsp_ram.sv -----
// generic ram: one write port, two read ports, registered read data
// no dependencies
module apsp_ram #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 256
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr_a,
	input logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0] rdata_a_q,
	output logic [WIDTH-1:0] rdata_b_q
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a_q <= mem_q[raddr_a];
		rdata_b_q <= mem_q[raddr_b];
	end
endmodule

// ----- rtl/apsp_seq.sv -----
// microcode sequencer: step counter, control store lookup, conditional jumps
// depends on apsp_pkg for the control word, flags and program
module apsp_seq (
	input logic clk,
	input logic arst_n,
	input apsp_pkg::seq_flags_t flags,
	output apsp_pkg::ctrl_word_t ctrl
);
	import apsp_pkg::*;

	step_t upc_q;
	step_t upc_d;
	step_t upc_inc;
	logic take;

	always_comb begin
		ctrl = ucode(upc_q);
	end

	always_comb begin
		upc_inc = step_t'(5'(upc_q) + 5'd1);
		case (ctrl.cond)
			C_NEVER: take = 1'b0;
			C_ALWAYS: take = 1'b1;
			C_SWEEP_MORE: take = flags.sweep_more;
			C_NO_PEND: take = !flags.pend;
			C_OUT_BUSY: take = flags.out_busy;
			C_BAD: take = flags.bad;
			C_NZERO: take = flags.n_zero;
			C_KIJ_MORE: take = flags.kij_more;
			default: take = 1'b0;
		endcase
		if (ctrl.cond == C_DISPATCH) begin
			// jump table indexed by the command mode
			upc_d = flags.accepted ?
				step_t'(5'(ctrl.target) + 5'(flags.mode)) : upc_q;
		end else begin
			upc_d = take ? ctrl.target : upc_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= S_CLR;
		end else begin
			upc_q <= upc_d;
		end
	end
endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// self-checking bench for all_pairs_shortest_path_top: directed table, then random episodes
// depends on apsp_pkg, apsp_in_if, apsp_out_if and the block itself
module tb_top;
	import apsp_pkg::*;

	localparam int MAX_V = MAX_VERTICES_DEF;
	localparam longint DIST_HI = (longint'(1) <<< (DIST_BITS_DEF - 1)) - 1;
	localparam longint DIST_LO = -DIST_HI - 1;
	// worst case: every beat a full closure at 16 vertices, taken a few times over
	localparam int CYCLE_LIMIT = 15_000_000;
	localparam int REPORT_CAP = 40;

	typedef enum logic [1:0] {
		IDLE_NONE,
		IDLE_SEND,
		IDLE_RECV,
		IDLE_BOTH
	} idle_mode_t;

	// one row of the directed table; fixed rows carry their result, others use the predictor
	typedef struct packed {
		logic set_cnt;
		logic [VCOUNT_W-1:0] cnt;
		mode_t mode;
		logic [VERTEX_W-1:0] from_v;
		logic [VERTEX_W-1:0] to_v;
		logic signed [WEIGHT_W-1:0] weight;
		logic fixed;
		logic signed [DISTANCE_W-1:0] want_dist;
		logic want_unr;
		logic want_stat;
	} cmd_row_t;

	typedef struct {
		out_item_t want;
		int beat_no;
	} pending_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [VCOUNT_W-1:0] cfg_wdata;

	apsp_in_if item_ch ();
	apsp_out_if result_ch ();

	all_pairs_shortest_path_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.item(item_ch),
		.result(result_ch)
	);

	// shadow of the block: distance matrix, no-path flags and vertex count
	longint path_len [MAX_V*MAX_V];
	bit no_path [MAX_V*MAX_V];
	logic [VCOUNT_W-1:0] vertex_count_q;

	pending_t pending_results [$];
	idle_mode_t idle_mode;
	int fault_cnt = 0;
	int beats_sent;
	int results_seen = 0;
	int closure_runs;
	int cycles_run;

	//          set   cnt   mode        from   to     weight       fix   dist          unr   st
	cmd_row_t directed_rows [25] = '{
		// fresh matrix after reset: diagonal zero, everything else unreachable
		'{1'b0, 5'd0, MODE_READ, 4'd0, 4'd0, 16'sd0, 1'b1, 32'sd0, 1'b0, 1'b0},
		'{1'b0, 5'd0, MODE_READ, 4'd0, 4'd15, 16'sd0, 1'b1, 32'sd0, 1'b1, 1'b0},
		'{1'b0, 5'd0, MODE_READ, 4'd15, 4'd15, 16'sd0, 1'b1, 32'sd0, 1'b0, 1'b0},
		// weight extremes written and read back
		'{1'b0, 5'd0, MODE_WRITE, 4'd0, 4'd1, 16'sh7fff, 1'b1, 32'sd0, 1'b0, 1'b0},
		'{1'b0, 5'd0, MODE_READ, 4'd0, 4'd1, 16'sd0, 1'b1, 32'sd32767, 1'b0, 1'b0},
		'{1'b0, 5'd0, MODE_WRITE, 4'd1, 4'd2, 16'sh8000, 1'b1, 32'sd0, 1'b0, 1'b0},
		'{1'b0, 5'd0, MODE_READ, 4'd1, 4'd2, 16'sd0, 1'b1, -32'sd32768, 1'b0, 1'b0},
		// diagonal overwrite, last write wins
		'{1'b0, 5'd0, MODE_WRITE, 4'd3, 4'd3, -16'sd5, 1'b1, 32'sd0, 1'b0, 1'b0},
		'{1'b0, 5'd0, MODE_READ, 4'd3, 4'd3, 16'sd0, 1'b1, -32'sd5, 1'b0, 1'b0},
		// closure at full size, then paths through and around unreachable entries
		'{1'b0, 5'd0, MODE_CLOSE, 4'd15, 4'd15, 16'shffff, 1'b1, 32'sd0, 1'b0, 1'b0},
		'{1'b0, 5'd0, MODE_READ, 4'd0, 4'd2, 16'sd0, 1'b0, 32'sd0, 1'b0, 1'b0},
		'{1'b0, 5'd0, MODE_READ, 4'd3, 4'd3, 16'sd0, 1'b0, 32'sd0, 1'b0, 1'b0},
		'{1'b0, 5'd0, MODE_READ, 4'd2, 4'd0, 16'sd0, 1'b0, 32'sd0, 1'b0, 1'b0},
		// clear ignores its fields and restores the fresh matrix
		'{1'b0, 5'd0, MODE_CLEAR, 4'd7, 4'd9, 16'sh1234, 1'b1, 32'sd0, 1'b0, 1'b0},
		'{1'b0, 5'd0, MODE_READ, 4'd0, 4'd1, 16'sd0, 1'b1, 32'sd0, 1'b1, 1'b0},
		'{1'b0, 5'd0, MODE_READ, 4'd3, 4'd3, 16'sd0, 1'b1, 32'sd0, 1'b0, 1'b0},
		// zero vertices: every index is out of range, closure is a no-op
		'{1'b1, 5'd0, MODE_WRITE, 4'd0, 4'd0, 16'sd1, 1'b1, 32'sd0, 1'b0, 1'b1},
		'{1'b0, 5'd0, MODE_READ, 4'd0, 4'd0, 16'sd0, 1'b1, 32'sd0, 1'b0, 1'b1},
		'{1'b0, 5'd0, MODE_CLOSE, 4'd0, 4'd0, 16'sd0, 1'b1, 32'sd0, 1'b0, 1'b0},
		// count above the maximum acts as the maximum
		'{1'b1, 5'd31, MODE_READ, 4'd15, 4'd15, 16'sd0, 1'b1, 32'sd0, 1'b0, 1'b0},
		// single vertex: negative self loop doubles through the closure
		'{1'b1, 5'd1, MODE_WRITE, 4'd0, 4'd0, 16'sh8000, 1'b1, 32'sd0, 1'b0, 1'b0},
		'{1'b0, 5'd0, MODE_READ, 4'd0, 4'd1, 16'sd0, 1'b1, 32'sd0, 1'b0, 1'b1},
		'{1'b0, 5'd0, MODE_READ, 4'd1, 4'd0, 16'sd0, 1'b1, 32'sd0, 1'b0, 1'b1},
		'{1'b0, 5'd0, MODE_CLOSE, 4'd0, 4'd0, 16'sd0, 1'b1, 32'sd0, 1'b0, 1'b0},
		'{1'b0, 5'd0, MODE_READ, 4'd0, 4'd0, 16'sd0, 1'b0, 32'sd0, 1'b0, 1'b0}
	};

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int active_vertices();
		return (vertex_count_q > MAX_V) ? MAX_V : int'(vertex_count_q);
	endfunction

	function automatic void clear_matrix();
		for (int i = 0; i < MAX_V; i++)
			for (int j = 0; j < MAX_V; j++) begin
				path_len[i*MAX_V+j] = 0;
				no_path[i*MAX_V+j] = (i != j);
			end
	endfunction

	// applies one command beat to the shadow matrix and returns its result beat
	function automatic out_item_t predict_shortest_path(in_item_t beat);
		out_item_t r;
		int n;
		int idx;
		int ik;
		int kj;
		int ij;
		longint s;
		r = '0;
		n = active_vertices();
		case (beat.mode)
			MODE_CLEAR: begin
				clear_matrix();
			end
			MODE_CLOSE: begin
				// in-place relaxation, intermediate k outermost, then row i, then column j
				for (int k = 0; k < n; k++)
					for (int i = 0; i < n; i++)
						for (int j = 0; j < n; j++) begin
							ik = i*MAX_V + k;
							kj = k*MAX_V + j;
							ij = i*MAX_V + j;
							// a path through a missing edge never replaces anything
							if (no_path[ik] || no_path[kj])
								continue;
							s = path_len[ik] + path_len[kj];
							if (s > DIST_HI)
								s = DIST_HI;
							else if (s < DIST_LO)
								s = DIST_LO;
							if (no_path[ij] || s < path_len[ij]) begin
								path_len[ij] = s;
								no_path[ij] = 1'b0;
							end
						end
			end
			default: begin
				if (beat.from_vertex >= n || beat.to_vertex >= n) begin
					r.status = 1'b1;
				end else begin
					idx = beat.from_vertex*MAX_V + beat.to_vertex;
					if (beat.mode == MODE_WRITE) begin
						path_len[idx] = $signed(beat.edge_weight);
						no_path[idx] = 1'b0;
					end else if (no_path[idx]) begin
						r.unreachable = 1'b1;
					end else begin
						r.distance = path_len[idx][DISTANCE_W-1:0];
					end
				end
			end
		endcase
		return r;
	endfunction

	// offer one beat, hold it until taken, then queue what it should produce
	task automatic send_beat(in_item_t beat, bit fixed, out_item_t want);
		int gap_pct;
		out_item_t model;
		pending_t exp_entry;
		gap_pct = (idle_mode == IDLE_SEND) ? 75 : (idle_mode == IDLE_BOTH) ? 16 : 0;
		while ($urandom_range(0, 99) < gap_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.data <= beat;
		do
			@(posedge clk);
		while (item_ch.ready !== 1'b1);
		model = predict_shortest_path(beat);
		exp_entry.want = fixed ? want : model;
		exp_entry.beat_no = beats_sent;
		pending_results.insert(pending_results.size(), exp_entry);
		beats_sent++;
		if (beat.mode == MODE_CLOSE)
			closure_runs++;
	endtask

	task automatic issue(mode_t m, logic [3:0] from_v, logic [3:0] to_v,
			logic signed [15:0] w);
		send_beat('{m, from_v, to_v, w}, 1'b0, '0);
	endtask

	// stop offering, wait until every result is back, then let the block settle
	task automatic drain();
		item_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// register writes only while nothing is in flight
	task automatic set_vertex_count(logic [VCOUNT_W-1:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		vertex_count_q = v;
	endtask

	// mostly in-range vertices, some anywhere in the field
	function automatic logic [3:0] rand_vertex(int n);
		if (n > 0 && $urandom_range(0, 9) != 0)
			return 4'($urandom_range(0, n - 1));
		return 4'($urandom_range(0, 15));
	endfunction

	function automatic logic signed [15:0] rand_weight();
		if ($urandom_range(0, 1) == 1)
			return 16'($urandom);
		return 16'($urandom_range(0, 60)) - 16'sd10;
	endfunction

	// random episodes: noise beats, build-and-solve graphs, negative loop pumping
	task automatic run_phase(idle_mode_t m, logic [VCOUNT_W-1:0] count, int beats);
		int target;
		int n;
		int pick;
		logic [3:0] v;
		set_vertex_count(count);
		idle_mode = m;
		n = active_vertices();
		target = beats_sent + beats;
		while (beats_sent < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 15) begin
				// anything the fields allow
				issue(mode_t'($urandom_range(0, 3)), 4'($urandom), 4'($urandom), 16'($urandom));
			end else if (pick < 30 && n <= 4) begin
				// a strong negative self loop doubled until the sums hit the floor
				v = rand_vertex(n);
				issue(MODE_WRITE, v, v, 16'(0 - $urandom_range(16384, 32768)));
				repeat (20) issue(MODE_CLOSE, rand_vertex(0), rand_vertex(0), rand_weight());
				issue(MODE_READ, v, v, rand_weight());
				issue(MODE_READ, rand_vertex(n), rand_vertex(n), rand_weight());
			end else begin
				// well-formed: optional clear, a handful of edges, closure, some reads
				if ($urandom_range(0, 2) == 0)
					issue(MODE_CLEAR, rand_vertex(0), rand_vertex(0), rand_weight());
				repeat ($urandom_range(1, 8))
					issue(MODE_WRITE, rand_vertex(n), rand_vertex(n), rand_weight());
				issue(MODE_CLOSE, rand_vertex(0), rand_vertex(0), rand_weight());
				repeat ($urandom_range(1, 4))
					issue(MODE_READ, rand_vertex(n), rand_vertex(n), rand_weight());
			end
		end
	endtask

	// receiver side: ready pattern follows the current idling phase
	always @(posedge clk) begin
		case (idle_mode)
			IDLE_RECV: result_ch.ready <= ($urandom_range(0, 99) >= 75);
			IDLE_BOTH: result_ch.ready <= ($urandom_range(0, 99) >= 16);
			default: result_ch.ready <= 1'b1;
		endcase
	end

	// every result beat against the oldest waiting expectation
	always @(posedge clk) begin
		pending_t exp_beat;
		out_item_t got;
		if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			got = result_ch.data;
			results_seen++;
			if (pending_results.size() == 0) begin
				fault_cnt++;
				if (fault_cnt <= REPORT_CAP)
					$display("%0t: unexpected result distance %0d unreachable %0b status %0b",
						$time, $signed(got.distance), got.unreachable, got.status);
			end else begin
				exp_beat = pending_results.pop_front();
				if (got.distance !== exp_beat.want.distance) begin
					fault_cnt++;
					if (fault_cnt <= REPORT_CAP)
						$display("%0t: beat %0d distance expected %0d actual %0d", $time,
							exp_beat.beat_no, $signed(exp_beat.want.distance),
							$signed(got.distance));
				end
				if (got.unreachable !== exp_beat.want.unreachable) begin
					fault_cnt++;
					if (fault_cnt <= REPORT_CAP)
						$display("%0t: beat %0d unreachable expected %0b actual %0b", $time,
							exp_beat.beat_no, exp_beat.want.unreachable, got.unreachable);
				end
				if (got.status !== exp_beat.want.status) begin
					fault_cnt++;
					if (fault_cnt <= REPORT_CAP)
						$display("%0t: beat %0d status expected %0b actual %0b", $time,
							exp_beat.beat_no, exp_beat.want.status, got.status);
				end
			end
		end
	end

	// watchdog: covers the post-reset clearing pass and the slowest legal run
	initial begin
		cycles_run = 0;
		while (cycles_run < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles_run++;
		end
		$display("tb_top: timeout after %0d cycles, %0d results outstanding",
			cycles_run, pending_results.size());
		$display("tb_top: errors");
		$finish;
	end

	initial begin
		cmd_row_t row;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		item_ch.valid = 1'b0;
		item_ch.data = '0;
		idle_mode = IDLE_NONE;
		beats_sent = 0;
		closure_runs = 0;
		vertex_count_q = VERTEX_COUNT_RST;
		clear_matrix();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed table, no idling; the first beat waits out the clearing pass
		foreach (directed_rows[r]) begin
			row = directed_rows[r];
			if (row.set_cnt)
				set_vertex_count(row.cnt);
			send_beat('{row.mode, row.from_v, row.to_v, row.weight}, row.fixed,
				'{row.want_dist, row.want_unr, row.want_stat});
		end

		// random part: each phase its own idling pattern and vertex count
		run_phase(IDLE_NONE, 5'd4, 18);
		run_phase(IDLE_SEND, 5'd16, 18);
		run_phase(IDLE_RECV, 5'd2, 18);
		run_phase(IDLE_BOTH, 5'd31, 18);
		run_phase(IDLE_NONE, 5'd7, 18);

		drain();
		$display("tb_top summary: %0d command beats (%0d from the table), %0d results checked",
			beats_sent, $size(directed_rows), results_seen);
		$display("tb_top summary: %0d closure runs over vertex counts 0 to 31, %0d mismatches",
			closure_runs, fault_cnt);
		if (fault_cnt == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule

// ----- all_pairs_shortest_path_top.f -----
rtl/apsp_pkg.sv
rtl/apsp_in_if.sv
rtl/apsp_out_if.sv
rtl/apsp_ram.sv
rtl/apsp_seq.sv
rtl/all_pairs_shortest_path_top.sv
dv/tb_top.sv
